FILE: rtl/spsa_pkg.sv
package spsa_pkg;

   // Default sizes
   localparam int MAX_SCOPES_DEF  = 256;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF   = 48;

   // Fixed field widths of the item formats
   localparam int REQ_W   = 2;
   localparam int ID_W    = 8;
   localparam int TS_W    = 48;
   localparam int ST_W    = 3;
   localparam int CALLS_W = 32;
   localparam int DEPTH_W = 7;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
   localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   // Status codes
   localparam logic [ST_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [ST_W-1:0] STATUS_OVERFLOW = 3'd1;
   localparam logic [ST_W-1:0] STATUS_MISMATCH = 3'd2;
   localparam logic [ST_W-1:0] STATUS_BAD_ID   = 3'd3;
   localparam logic [ST_W-1:0] STATUS_DISABLED = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [ID_W-1:0]  scope_id;
      logic [TS_W-1:0]  timestamp;
   } req_item_type;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [CALLS_W-1:0] call_count;
      logic [TS_W-1:0]    self_total;
      logic [TS_W-1:0]    cum_total;
      logic [DEPTH_W-1:0] active_depth;
      logic [TS_W-1:0]    frame_elapsed;
   } rsp_item_type;

   // Command from the event logic to the frame stack
   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] scope;
   } stack_cmd_type;

   // Frame stack status seen by the event logic
   typedef struct packed {
      logic            empty;
      logic            full;
      logic [ID_W-1:0] top_scope;
   } stack_state_type;

   typedef enum logic {
      CLR_SWEEP,
      CLR_IDLE
   } clr_state_type;

endpackage

FILE: rtl/spsa_stats.sv
module spsa_stats #(
   parameter int MAX_SCOPES = spsa_pkg::MAX_SCOPES_DEF,
   parameter int TIME_BITS  = spsa_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           busy,
   input  logic                           rd_en,
   input  logic [$clog2(MAX_SCOPES)-1:0]  rd_idx,
   output logic [spsa_pkg::CALLS_W-1:0]   rd_calls,
   output logic [spsa_pkg::DEPTH_W-1:0]   rd_active,
   output logic [TIME_BITS-1:0]           rd_self,
   output logic [TIME_BITS-1:0]           rd_cum,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_SCOPES)-1:0]  wr_idx,
   input  logic [spsa_pkg::CALLS_W-1:0]   wr_calls,
   input  logic [spsa_pkg::DEPTH_W-1:0]   wr_active,
   input  logic [TIME_BITS-1:0]           wr_self,
   input  logic [TIME_BITS-1:0]           wr_cum
);

   localparam int IW     = $clog2(MAX_SCOPES);
   localparam int STAT_W = spsa_pkg::CALLS_W + spsa_pkg::DEPTH_W + 2 * TIME_BITS;

   logic [STAT_W-1:0] mem [MAX_SCOPES];
   logic [STAT_W-1:0] rd_ff;
   logic [STAT_W-1:0] wd;

   spsa_pkg::clr_state_type state_ff, state_in;
   logic [IW-1:0]           clr_ff, clr_in;

   assign wd = {wr_calls, wr_active, wr_self, wr_cum};
   assign {rd_calls, rd_active, rd_self, rd_cum} = rd_ff;
   assign busy = (state_ff == spsa_pkg::CLR_SWEEP);

   // Clear sweep after reset, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spsa_pkg::CLR_SWEEP;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         spsa_pkg::CLR_SWEEP: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(MAX_SCOPES - 1)) begin
               state_in = spsa_pkg::CLR_IDLE;
            end
         end
         spsa_pkg::CLR_IDLE: begin
            clr_in = clr_ff;
         end
         default: begin
            state_in = spsa_pkg::CLR_SWEEP;
            clr_in   = '0;
         end
      endcase
   end

   // Read data bypasses a write to the same entry in the same cycle
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_idx] <= wd;
      end
      if (rd_en) begin
         rd_ff <= (wr_en && (wr_idx == rd_idx)) ? wd : mem[rd_idx];
      end
   end

endmodule

FILE: rtl/spsa_stack.sv
module spsa_stack #(
   parameter int STACK_DEPTH = spsa_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = spsa_pkg::TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spsa_pkg::stack_cmd_type   cmd,
   input  logic [TIME_BITS-1:0]      push_time,
   input  logic [TIME_BITS-1:0]      pop_elapsed,
   output spsa_pkg::stack_state_type state,
   output logic [TIME_BITS-1:0]      top_start,
   output logic [TIME_BITS-1:0]      top_child
);

   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W   = $clog2(STACK_DEPTH);
   localparam int FRAME_W = spsa_pkg::ID_W + 2 * TIME_BITS;

   // Top two frames live in registers; deeper frames in the memory.
   // rd_ff always holds the third frame from the top.
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [FRAME_W-1:0] t0_ff, t0_in;
   logic [FRAME_W-1:0] t1_ff, t1_in;
   logic [FRAME_W-1:0] rd_ff;
   logic [FRAME_W-1:0] mem [STACK_DEPTH];

   logic [SP_W-1:0]    wa_full, ra_full;
   logic [IDX_W-1:0]   wa, ra;
   logic               we;
   logic [TIME_BITS:0] child_sum;
   logic [TIME_BITS-1:0] child_new;

   assign state.empty     = (sp_ff == '0);
   assign state.full      = (sp_ff >= SP_W'(STACK_DEPTH));
   assign state.top_scope = t0_ff[FRAME_W-1 -: spsa_pkg::ID_W];
   assign top_start       = t0_ff[2*TIME_BITS-1 -: TIME_BITS];
   assign top_child       = t0_ff[TIME_BITS-1:0];

   assign child_sum = {1'b0, t1_ff[TIME_BITS-1:0]} + {1'b0, pop_elapsed};
   assign child_new = child_sum[TIME_BITS] ? '1 : child_sum[TIME_BITS-1:0];

   assign we      = cmd.push && (sp_ff >= SP_W'(2));
   assign wa_full = sp_ff - SP_W'(2);
   assign ra_full = sp_in - SP_W'(3);
   assign wa      = wa_full[IDX_W-1:0];
   assign ra      = ra_full[IDX_W-1:0];

   always_comb begin
      sp_in = sp_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      if (cmd.push) begin
         sp_in = sp_ff + 1'b1;
         t0_in = {cmd.scope, push_time, {TIME_BITS{1'b0}}};
         t1_in = t0_ff;
      end else if (cmd.pop) begin
         sp_in = sp_ff - 1'b1;
         t0_in = {t1_ff[FRAME_W-1:TIME_BITS], child_new};
         t1_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      if (we) begin
         mem[wa] <= t1_ff;
      end
      rd_ff <= (we && (wa == ra)) ? t1_ff : mem[ra];
   end

endmodule

FILE: rtl/scope_profiler_stack_accounting_core.sv
// Scope profiler with call-stack accounting.
//
// Request channel (req_valid / req_stall / req_item): begin, end or read
// events, each with a scope id and a timestamp. An item is taken at a clock
// edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_item): exactly one response
// item per request, in order, carrying status and the scope's statistics.
// CSR channel (csr_valid / csr_ready / csr_wdata): writes the enable bit;
// csr_ready is always high. Write it only while no request is in flight.
//
// A request taken at an edge goes into the event stage register and from there
// into the output register. Throughput is one item per cycle while the response
// side does not stall; the stats table does its read at acceptance and its write
// when the item leaves the event stage, with a bypass when back-to-back items hit the same scope.
// Reset clears the stack pointer and enable, then the stats table is swept to
// zero, one entry after another, with req_stall held high; CSR writes are still
// taken. A stalled response holds the output register; the one item in the
// event stage waits behind it and req_stall rises until it can move.
module scope_profiler_stack_accounting_core #(
   parameter int MAX_SCOPES  = spsa_pkg::MAX_SCOPES_DEF,
   parameter int STACK_DEPTH = spsa_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = spsa_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  spsa_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spsa_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);

   localparam int IW = $clog2(MAX_SCOPES);

   // Pipeline control
   logic                   s1_valid_ff, s1_valid_in;
   spsa_pkg::req_item_type s1_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   spsa_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                   enable_ff, enable_in;
   logic                   accept, advance, clearing;

   // Stats table access
   logic [31:0]                  req_id_ext, s1_id_ext;
   logic [IW-1:0]                rd_idx, wr_idx;
   logic [spsa_pkg::CALLS_W-1:0] rd_calls, wr_calls;
   logic [spsa_pkg::DEPTH_W-1:0] rd_active, wr_active;
   logic [TIME_BITS-1:0]         rd_self, rd_cum, wr_self, wr_cum;
   logic                         wr_en, do_write;

   // Frame stack
   spsa_pkg::stack_cmd_type   stk_cmd;
   spsa_pkg::stack_state_type stk_state;
   logic [TIME_BITS-1:0]      top_start, top_child;

   // Event datapath
   logic [TIME_BITS-1:0] now_t, elapsed, self_t, self_new, cum_new;
   logic [TIME_BITS:0]   self_sum, cum_sum;
   logic [spsa_pkg::CALLS_W-1:0] calls_inc;
   logic [spsa_pkg::DEPTH_W-1:0] active_inc, active_dec;
   logic                         id_ok;

   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_wdata : enable_ff;

   // Event stage moves when the output register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Table index: the id zero-extended, then cut to the table's index width
   assign req_id_ext = 32'(req_item.scope_id);
   assign s1_id_ext  = 32'(s1_item_ff.scope_id);
   assign rd_idx     = req_id_ext[IW-1:0];
   assign wr_idx     = s1_id_ext[IW-1:0];
   assign wr_en      = advance && do_write;

   spsa_stats #(
      .MAX_SCOPES (MAX_SCOPES),
      .TIME_BITS  (TIME_BITS)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .busy      (clearing),
      .rd_en     (accept),
      .rd_idx    (rd_idx),
      .rd_calls  (rd_calls),
      .rd_active (rd_active),
      .rd_self   (rd_self),
      .rd_cum    (rd_cum),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_calls  (wr_calls),
      .wr_active (wr_active),
      .wr_self   (wr_self),
      .wr_cum    (wr_cum)
   );

   spsa_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .cmd         (stk_cmd),
      .push_time   (now_t),
      .pop_elapsed (elapsed),
      .state       (stk_state),
      .top_start   (top_start),
      .top_child   (top_child)
   );

   // Timestamp is cut (or zero-extended) to the internal time width
   assign now_t = TIME_BITS'(64'(s1_item_ff.timestamp));
   assign id_ok = (s1_id_ext < 32'(MAX_SCOPES));

   // End-event arithmetic: wrapping elapsed, self time floors at zero
   assign elapsed  = now_t - top_start;
   assign self_t   = (top_child > elapsed) ? '0 : (elapsed - top_child);
   assign self_sum = {1'b0, rd_self} + {1'b0, self_t};
   assign self_new = self_sum[TIME_BITS] ? '1 : self_sum[TIME_BITS-1:0];
   assign active_dec = (rd_active != '0) ? (rd_active - 1'b1) : '0;
   assign cum_sum  = {1'b0, rd_cum} + {1'b0, elapsed};
   assign cum_new  = (active_dec == '0)
                     ? (cum_sum[TIME_BITS] ? '1 : cum_sum[TIME_BITS-1:0])
                     : rd_cum;

   // Begin-event counters, both saturating
   assign calls_inc  = (rd_calls != '1) ? (rd_calls + 1'b1) : rd_calls;
   assign active_inc = (rd_active != '1) ? (rd_active + 1'b1) : rd_active;

   always_comb begin
      logic [63:0] self_w, cum_w, el_w;
      logic        stats;
      logic [spsa_pkg::ST_W-1:0] status;
      logic [TIME_BITS-1:0]      out_self, out_cum, out_el;
      logic [spsa_pkg::CALLS_W-1:0] out_calls;
      logic [spsa_pkg::DEPTH_W-1:0] out_active;

      status     = spsa_pkg::STATUS_OK;
      stats      = 1'b0;
      out_calls  = rd_calls;
      out_active = rd_active;
      out_self   = rd_self;
      out_cum    = rd_cum;
      out_el     = '0;
      do_write   = 1'b0;
      wr_calls   = rd_calls;
      wr_active  = rd_active;
      wr_self    = rd_self;
      wr_cum     = rd_cum;
      stk_cmd.push  = 1'b0;
      stk_cmd.pop   = 1'b0;
      stk_cmd.scope = s1_item_ff.scope_id;

      if (!enable_ff) begin
         status = spsa_pkg::STATUS_DISABLED;
      end else if (!id_ok) begin
         status = spsa_pkg::STATUS_BAD_ID;
      end else begin
         case (s1_item_ff.req_type)
            spsa_pkg::REQ_READ: begin
               stats = 1'b1;
            end
            spsa_pkg::REQ_BEGIN: begin
               if (stk_state.full) begin
                  status = spsa_pkg::STATUS_OVERFLOW;
               end else begin
                  stats        = 1'b1;
                  do_write     = 1'b1;
                  stk_cmd.push = advance;
                  wr_calls     = calls_inc;
                  wr_active    = active_inc;
                  out_calls    = calls_inc;
                  out_active   = active_inc;
               end
            end
            spsa_pkg::REQ_END: begin
               if (stk_state.empty || (stk_state.top_scope != s1_item_ff.scope_id)) begin
                  status = spsa_pkg::STATUS_MISMATCH;
               end else begin
                  stats       = 1'b1;
                  do_write    = 1'b1;
                  stk_cmd.pop = advance;
                  wr_active   = active_dec;
                  wr_self     = self_new;
                  wr_cum      = cum_new;
                  out_active  = active_dec;
                  out_self    = self_new;
                  out_cum     = cum_new;
                  out_el      = elapsed;
               end
            end
            default: begin
               // unused request code is refused like a bad id
               status = spsa_pkg::STATUS_BAD_ID;
            end
         endcase
      end

      // Internal time width to the 48-bit response fields
      self_w = 64'(out_self);
      cum_w  = 64'(out_cum);
      el_w   = 64'(out_el);

      rsp_item_in.status        = status;
      rsp_item_in.call_count    = stats ? out_calls : '0;
      rsp_item_in.self_total    = stats ? self_w[spsa_pkg::TS_W-1:0] : '0;
      rsp_item_in.cum_total     = stats ? cum_w[spsa_pkg::TS_W-1:0] : '0;
      rsp_item_in.active_depth  = stats ? out_active : '0;
      rsp_item_in.frame_elapsed = el_w[spsa_pkg::TS_W-1:0];
   end

endmodule

FILE: sim/spsa_checker.sv
`timescale 1ns / 1ps

module spsa_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  spsa_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  spsa_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);

   localparam int ID_W       = spsa_pkg::ID_W;
   localparam int TS_W       = spsa_pkg::TS_W;
   localparam int CALLS_W    = spsa_pkg::CALLS_W;
   localparam int DEPTH_W    = spsa_pkg::DEPTH_W;
   localparam int NUM_SCOPES = spsa_pkg::MAX_SCOPES_DEF;
   localparam int NUM_FRAMES = spsa_pkg::STACK_DEPTH_DEF;
   localparam int FRAME_IW   = $clog2(NUM_FRAMES);
   localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;
   localparam logic [CALLS_W-1:0] CALLS_SAT = '1;

   // Own copy of the profiler state
   logic               session_on;
   logic [ID_W-1:0]    frame_id    [NUM_FRAMES];
   logic [TS_W-1:0]    frame_t0    [NUM_FRAMES];
   logic [TS_W-1:0]    frame_child [NUM_FRAMES];
   int                 frame_count;
   logic [CALLS_W-1:0] calls      [NUM_SCOPES];
   logic [DEPTH_W-1:0] live_depth [NUM_SCOPES];
   logic [TS_W-1:0]    self_ns    [NUM_SCOPES];
   logic [TS_W-1:0]    cum_ns     [NUM_SCOPES];

   spsa_pkg::rsp_item_type predicted_stats_q[$];

   initial mismatch_count = 0;
   initial outstanding = 0;

   function automatic logic [TS_W-1:0] sat_add_ns(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
      logic [TS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TS_W] ? '1 : sum[TS_W-1:0];
   endfunction

   function automatic spsa_pkg::rsp_item_type stats_of(logic [ID_W-1:0] id,
                                                       logic [TS_W-1:0] elapsed);
      spsa_pkg::rsp_item_type r;
      r = '0;
      r.status        = spsa_pkg::STATUS_OK;
      r.call_count    = calls[id];
      r.self_total    = self_ns[id];
      r.cum_total     = cum_ns[id];
      r.active_depth  = live_depth[id];
      r.frame_elapsed = elapsed;
      return r;
   endfunction

   // Applies one event to the state and returns the response it must produce
   function automatic spsa_pkg::rsp_item_type account_event(spsa_pkg::req_item_type ev);
      spsa_pkg::rsp_item_type r;
      logic [ID_W-1:0]  id;
      logic [TS_W-1:0]  elapsed;
      logic [TS_W-1:0]  child;
      logic [TS_W-1:0]  self_t;
      int               top;
      r  = '0;
      id = ev.scope_id;
      if (!session_on) begin
         r.status = spsa_pkg::STATUS_DISABLED;
         return r;
      end
      if (int'(id) >= NUM_SCOPES) begin
         r.status = spsa_pkg::STATUS_BAD_ID;
         return r;
      end
      case (ev.req_type)
         spsa_pkg::REQ_READ: begin
            r = stats_of(id, '0);
         end
         spsa_pkg::REQ_BEGIN: begin
            if (frame_count >= NUM_FRAMES) begin
               r.status = spsa_pkg::STATUS_OVERFLOW;
            end else begin
               if (calls[id] != CALLS_SAT) calls[id] = calls[id] + 1'b1;
               if (live_depth[id] != DEPTH_SAT) live_depth[id] = live_depth[id] + 1'b1;
               frame_id[FRAME_IW'(frame_count)]    = id;
               frame_t0[FRAME_IW'(frame_count)]    = ev.timestamp;
               frame_child[FRAME_IW'(frame_count)] = '0;
               frame_count++;
               r = stats_of(id, '0);
            end
         end
         spsa_pkg::REQ_END: begin
            if (frame_count == 0 || frame_id[FRAME_IW'(frame_count-1)] != id) begin
               r.status = spsa_pkg::STATUS_MISMATCH;
            end else begin
               top         = frame_count - 1;
               frame_count = top;
               elapsed     = ev.timestamp - frame_t0[FRAME_IW'(top)];
               child       = frame_child[FRAME_IW'(top)];
               self_t      = (child > elapsed) ? '0 : elapsed - child;
               self_ns[id] = sat_add_ns(self_ns[id], self_t);
               if (live_depth[id] != '0) live_depth[id] = live_depth[id] - 1'b1;
               if (live_depth[id] == '0) cum_ns[id] = sat_add_ns(cum_ns[id], elapsed);
               if (top > 0) begin
                  frame_child[FRAME_IW'(top-1)] =
                     sat_add_ns(frame_child[FRAME_IW'(top-1)], elapsed);
               end
               r = stats_of(id, elapsed);
            end
         end
         default: begin
            r.status = spsa_pkg::STATUS_BAD_ID;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0h, actual %0h", fname, want, got);
      end
   endtask

   always @(posedge clock) begin
      spsa_pkg::rsp_item_type want;
      if (reset) begin
         session_on  = 1'b0;
         frame_count = 0;
         for (int i = 0; i < NUM_SCOPES; i++) begin
            calls[ID_W'(i)]      = '0;
            live_depth[ID_W'(i)] = '0;
            self_ns[ID_W'(i)]    = '0;
            cum_ns[ID_W'(i)]     = '0;
         end
         predicted_stats_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) session_on = csr_wdata;
         // responses always belong to earlier items, so retire before adding
         if (rsp_valid && !rsp_stall) begin
            if (predicted_stats_q.size() == 0) begin
               mismatch_count++;
               $error("response item with no request outstanding");
            end else begin
               want = predicted_stats_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_item.status));
               check_field("call_count", 64'(want.call_count), 64'(rsp_item.call_count));
               check_field("self_total", 64'(want.self_total), 64'(rsp_item.self_total));
               check_field("cum_total", 64'(want.cum_total), 64'(rsp_item.cum_total));
               check_field("active_depth", 64'(want.active_depth),
                           64'(rsp_item.active_depth));
               check_field("frame_elapsed", 64'(want.frame_elapsed),
                           64'(rsp_item.frame_elapsed));
            end
         end
         if (req_valid && !req_stall) begin
            predicted_stats_q = {predicted_stats_q, account_event(req_item)};
         end
         outstanding <= predicted_stats_q.size();
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int REQ_W = spsa_pkg::REQ_W;
   localparam int ID_W  = spsa_pkg::ID_W;
   localparam int TS_W  = spsa_pkg::TS_W;

   // Request code the block must refuse; the package has no name for it
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int NUM_FRAMES       = spsa_pkg::STACK_DEPTH_DEF;
   localparam int FRAME_IW         = $clog2(NUM_FRAMES);
   localparam int LONG_HOLD_CYCLES = 90;
   localparam logic [TS_W-1:0] TS_MAX = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   spsa_pkg::req_item_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   spsa_pkg::rsp_item_type rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_wdata = 1'b0;

   int mismatch_count;
   int outstanding;

   // Idle percentages of the two sides; the receiver's is changed by NBA only
   int send_idle_pct = 33;
   int recv_idle_pct = 85;
   logic long_hold_pending = 1'b0;
   logic long_hold_done    = 1'b0;

   // Sender-side picture of the stack, used only to shape well-formed sequences.
   // The checker alone decides what is right.
   logic            session_on = 1'b0;
   logic [ID_W-1:0] shadow_ids [NUM_FRAMES];
   int              shadow_depth = 0;
   logic [TS_W-1:0] now_ts;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   scope_profiler_stack_accounting_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   spsa_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Receiver: random stall, plus one long hold-off on request so the event
   // stage and output register fill and req_stall must rise.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending && !long_hold_done) begin
            long_hold_done <= 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Mostly small steps forward; sometimes a big jump that wraps, sometimes a
   // fully random time (can run backward, giving huge wrapped elapsed times).
   function automatic logic [TS_W-1:0] next_ts();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) now_ts = now_ts + TS_W'($urandom_range(1, 3000));
      else if (pick < 95) now_ts = now_ts + TS_W'({$urandom, $urandom});
      else now_ts = TS_W'({$urandom, $urandom});
      return now_ts;
   endfunction

   // Small pool of ids most of the time so recursion and nesting happen
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(3) == 0) return ID_W'($urandom_range(255));
      return ID_W'($urandom_range(7));
   endfunction

   // Offers one item at the current edge and returns at the edge it is taken
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{req_type: kind, scope_id: id, timestamp: ts};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (session_on) begin
         if (kind == spsa_pkg::REQ_BEGIN && shadow_depth < NUM_FRAMES) begin
            shadow_ids[FRAME_IW'(shadow_depth)] = id;
            shadow_depth++;
         end else if (kind == spsa_pkg::REQ_END && shadow_depth > 0 &&
                      shadow_ids[FRAME_IW'(shadow_depth-1)] == id) begin
            shadow_depth--;
         end
      end
   endtask

   // Mostly matched begin/end pairs with random content; the rest is reads
   // and noise (unused code, ends with a random id, extra begins).
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 42 && shadow_depth < NUM_FRAMES) begin
         send_item(spsa_pkg::REQ_BEGIN, pick_id(), next_ts());
      end else if (pick < 78 && shadow_depth > 0) begin
         send_item(spsa_pkg::REQ_END, shadow_ids[FRAME_IW'(shadow_depth-1)], next_ts());
      end else if (pick < 90) begin
         send_item(spsa_pkg::REQ_READ, pick_id(), next_ts());
      end else begin
         case ($urandom_range(2))
            0: send_item(REQ_UNUSED, ID_W'($urandom_range(255)), next_ts());
            1: send_item(spsa_pkg::REQ_END, ID_W'($urandom_range(255)), next_ts());
            default: send_item(spsa_pkg::REQ_BEGIN, pick_id(), next_ts());
         endcase
      end
   endtask

   // Drop valid and wait until every response is back, plus a short margin for the pipe.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      session_on = value;
   endtask

   initial begin
      now_ts = TS_MAX - TS_W'($urandom_range(50000));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // session off after reset: every event refused
      send_item(spsa_pkg::REQ_BEGIN, 8'd3, 48'd10);
      send_item(spsa_pkg::REQ_READ, 8'd3, 48'd20);
      drain();
      csr_write(1'b1);

      send_item(spsa_pkg::REQ_READ, 8'd0, 48'd0);   // untouched scope reads zero
      send_item(REQ_UNUSED, 8'hFF, 48'd0);          // unused request code
      send_item(spsa_pkg::REQ_END, 8'd0, 48'd1);    // end on an empty stack
      send_item(spsa_pkg::REQ_BEGIN, 8'd0, 48'd0);
      send_item(spsa_pkg::REQ_BEGIN, 8'hFF, TS_MAX);
      send_item(spsa_pkg::REQ_END, 8'd0, 48'd2);    // top is 255, not 0
      send_item(spsa_pkg::REQ_END, 8'hFF, 48'd5);   // elapsed wraps through zero
      // recursion: cum only counted when the outer frame closes
      send_item(spsa_pkg::REQ_BEGIN, 8'hFF, 48'd100);
      send_item(spsa_pkg::REQ_BEGIN, 8'hFF, 48'd200);
      send_item(spsa_pkg::REQ_END, 8'hFF, 48'd250);
      send_item(spsa_pkg::REQ_END, 8'hFF, 48'd400);
      // child elapsed wraps to a huge value, so the parent's self time is zero
      send_item(spsa_pkg::REQ_BEGIN, 8'd7, 48'd1000);
      send_item(spsa_pkg::REQ_END, 8'd7, 48'd400);
      send_item(spsa_pkg::REQ_END, 8'd0, 48'd2000);
      // second huge frame drives self and cum of scope 7 into saturation
      send_item(spsa_pkg::REQ_BEGIN, 8'd7, 48'd10);
      send_item(spsa_pkg::REQ_END, 8'd7, 48'd5);
      send_item(spsa_pkg::REQ_READ, 8'd7, 48'd0);
      send_item(spsa_pkg::REQ_READ, 8'hFF, TS_MAX);
      send_item(spsa_pkg::REQ_BEGIN, 8'd128, TS_MAX);
      send_item(spsa_pkg::REQ_END, 8'd128, TS_MAX); // zero elapsed
      send_item(spsa_pkg::REQ_READ, 8'd128, 48'hAAAA_5555_AAAA);
      drain();

      // ---- random, sender sparse-ish, receiver mostly stalled ----
      for (int i = 0; i < 120; i++) begin
         random_item();
         // sender pause: let everything come back mid-phase
         if (i == 60) drain();
      end
      drain();

      // session off for a while; stack and stats must survive untouched
      csr_write(1'b0);
      for (int i = 0; i < 8; i++) random_item();
      drain();
      csr_write(1'b1);

      // ---- random, roles swapped ----
      send_idle_pct = 85;
      recv_idle_pct <= 33;
      for (int i = 0; i < 120; i++) random_item();
      drain();

      // ---- random at full rate, starting under a long receiver hold-off ----
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      long_hold_pending <= 1'b1;
      for (int i = 0; i < 60; i++) random_item();

      // fill the stack to the top, overflow it once, then unwind to empty
      // and end once more on the empty stack
      while (shadow_depth < NUM_FRAMES) send_item(spsa_pkg::REQ_BEGIN, pick_id(), next_ts());
      send_item(spsa_pkg::REQ_BEGIN, pick_id(), next_ts());
      while (shadow_depth > 0) begin
         send_item(spsa_pkg::REQ_END, shadow_ids[FRAME_IW'(shadow_depth-1)], next_ts());
      end
      send_item(spsa_pkg::REQ_END, pick_id(), next_ts());
      drain();

      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
